// ===== rtl/fptr_pkg.sv =====
// Package for the flight profile transition ramp.
// Holds the mode and profile codes, register indexes, state and result
// types, and the profile transition table. No dependencies.
package fptr_pkg;

    localparam int STICK_W   = 12;
    localparam int SPEED_W   = 8;
    localparam int POINT_W   = 7;
    localparam int TIMER_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic signed [STICK_W-1:0] STICK_HI_THR = 12'sd500;
    localparam logic signed [STICK_W-1:0] STICK_LO_THR = -12'sd500;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_OUTBOUND_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INBOUND_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_MID      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_RESET   = 3'd5;

    localparam logic [POINT_W-1:0] POINT_LOW_RST  = 7'd0;
    localparam logic [POINT_W-1:0] POINT_MID_RST  = 7'd50;
    localparam logic [POINT_W-1:0] POINT_HIGH_RST = 7'd100;

    typedef enum logic [3:0] {
        MODE_P1      = 4'd0,
        MODE_P1N     = 4'd1,
        MODE_P2      = 4'd2,
        MODE_MOVING  = 4'd3,
        MODE_P1_P1N  = 4'd4,
        MODE_P1_P2   = 4'd5,
        MODE_P1N_P1  = 4'd6,
        MODE_P1N_P2  = 4'd7,
        MODE_P2_P1N  = 4'd8,
        MODE_P2_P1   = 4'd9
    } t_mode;

    // PROF_NONE marks the state before the first item.
    typedef enum logic [1:0] {
        PROF_P1   = 2'd0,
        PROF_P1N  = 2'd1,
        PROF_P2   = 2'd2,
        PROF_NONE = 2'd3
    } t_profile;

    typedef struct packed {
        logic [SPEED_W-1:0] outbound_speed;
        logic [SPEED_W-1:0] inbound_speed;
        logic [POINT_W-1:0] point_low;
        logic [POINT_W-1:0] point_mid;
        logic [POINT_W-1:0] point_high;
        logic               orient_reset_enable;
    } t_cfg;

    typedef struct packed {
        t_profile           last_profile;
        logic [SPEED_W-1:0] last_speed;
        t_mode              ramp_state;
        logic [POINT_W-1:0] ramp_counter;
        logic               toward_p2;
        logic [TIMER_W-1:0] tick_timer;
        t_mode              prev_state;
        logic [POINT_W-1:0] prev_blend;
    } t_state;

    typedef struct packed {
        logic [POINT_W-1:0] blend_value;
        t_mode              mode_state;
        logic               clear_p2_integral;
        logic               clear_p1_integral;
        logic               imu_reset;
    } t_result;

    // Start state of the ramp for a change from one profile to another.
    function automatic t_mode fptr_next_mode(input t_profile req, input t_profile prev);
        t_mode m;
        m = MODE_MOVING;
        case (req)
            PROF_P1: begin
                case (prev)
                    PROF_P1N: m = MODE_P1N_P1;
                    PROF_P2:  m = MODE_P2_P1;
                    default:  m = MODE_MOVING;
                endcase
            end
            PROF_P1N: begin
                case (prev)
                    PROF_P1: m = MODE_P1_P1N;
                    PROF_P2: m = MODE_P2_P1N;
                    default: m = MODE_MOVING;
                endcase
            end
            PROF_P2: begin
                case (prev)
                    PROF_P1:  m = MODE_P1_P2;
                    PROF_P1N: m = MODE_P1N_P2;
                    default:  m = MODE_MOVING;
                endcase
            end
            default: m = MODE_MOVING;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/fptr_in_if.sv =====
// Input channel of the flight profile transition ramp: one stick item.
// Valid/ready handshake. No dependencies.
interface fptr_in_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] profile_stick;

    modport source (output valid, output profile_stick, input ready);
    modport sink (input valid, input profile_stick, output ready);
endinterface

// ===== rtl/fptr_out_if.sv =====
// Result channel of the flight profile transition ramp.
// Valid/ready handshake. No dependencies.
interface fptr_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] blend_value;
    logic [3:0] mode_state;
    logic       clear_p2_integral;
    logic       clear_p1_integral;
    logic       imu_reset;

    modport source (output valid, output blend_value, output mode_state,
                    output clear_p2_integral, output clear_p1_integral,
                    output imu_reset, input ready);
    modport sink (input valid, input blend_value, input mode_state,
                  input clear_p2_integral, input clear_p1_integral,
                  input imu_reset, output ready);
endinterface

// ===== rtl/fptr_cfg.sv =====
// Configuration register bank of the flight profile transition ramp.
// Depends on fptr_pkg.
module fptr_cfg
    import fptr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OUTBOUND_SPEED: n_cfg.outbound_speed      = i_cfg_data;
                CFG_INBOUND_SPEED:  n_cfg.inbound_speed       = i_cfg_data;
                CFG_POINT_LOW:      n_cfg.point_low           = i_cfg_data[POINT_W-1:0];
                CFG_POINT_MID:      n_cfg.point_mid           = i_cfg_data[POINT_W-1:0];
                CFG_POINT_HIGH:     n_cfg.point_high          = i_cfg_data[POINT_W-1:0];
                CFG_ORIENT_RESET:   n_cfg.orient_reset_enable = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outbound_speed      <= '0;
            r_cfg.inbound_speed       <= '0;
            r_cfg.point_low           <= POINT_LOW_RST;
            r_cfg.point_mid           <= POINT_MID_RST;
            r_cfg.point_high          <= POINT_HIGH_RST;
            r_cfg.orient_reset_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/fptr_step.sv =====
// One control tick of the transition ramp: profile decode, ramp state update,
// blend value and flag outputs. Depends on fptr_pkg.
module fptr_step
    import fptr_pkg::*;
#(
    parameter int TICKS_PER_UNIT = 10
) (
    input  t_cfg                      i_cfg,
    input  t_state                    i_state,
    input  logic signed [STICK_W-1:0] i_stick,
    output t_state                    o_state,
    output t_result                   o_result
);

    localparam int TPU_W    = $clog2(TICKS_PER_UNIT + 1);
    localparam int PERIOD_W = SPEED_W + TPU_W;
    localparam logic [TPU_W-1:0] TPU = TPU_W'(TICKS_PER_UNIT);

    t_profile            profile;
    logic                reinit;
    logic                updated;
    logic                manual;
    t_mode               mode0;
    t_mode               mode1;
    t_mode               mode2;
    t_mode               end_mode;
    logic [POINT_W-1:0]  cnt0;
    logic [POINT_W-1:0]  cnt2;
    logic [POINT_W-1:0]  tgt;
    logic [POINT_W-1:0]  blend;
    logic                do_ramp;
    logic                toward_next;
    logic                fire;
    logic [SPEED_W-1:0]  speed;
    logic [PERIOD_W-1:0] period;
    logic [TIMER_W-1:0]  timer_next;
    logic [POINT_W:0]    cnt_inc;
    logic [POINT_W-1:0]  cnt_dec;

    // Manual blend datapath.
    logic signed [STICK_W:0] stick_off;
    logic [10:0]             blend_x;
    logic [8:0]              blend_y;
    logic [16:0]             blend_prod;
    logic [POINT_W-1:0]      manual_blend;

    logic clr2;
    logic clr1;
    logic imu;

    always_comb begin
        if (i_stick > STICK_HI_THR) begin
            profile = PROF_P2;
        end else if (i_stick > STICK_LO_THR) begin
            profile = PROF_P1N;
        end else begin
            profile = PROF_P1;
        end
    end

    // Stick blend is (max(0, stick + 1000) + 10) / 20 capped at 100. The
    // division by 20 is a shift by two and a multiply by 205/1024, exact below 1024.
    always_comb begin
        stick_off  = {i_stick[STICK_W-1], i_stick} + 13'sd1000;
        blend_x    = '0;
        blend_y    = '0;
        blend_prod = '0;
        if (stick_off < 13'sd0) begin
            manual_blend = 7'd0;
        end else if (stick_off >= 13'sd1990) begin
            manual_blend = 7'd100;
        end else begin
            blend_x      = stick_off[10:0] + 11'd10;
            blend_y      = blend_x[10:2];
            blend_prod   = 17'(blend_y) * 17'd205;
            manual_blend = blend_prod[16:10];
        end
    end

    // Next state: re-initialization, transition table and ramp step.
    always_comb begin
        manual = (i_cfg.outbound_speed == '0);
        reinit = (i_state.last_profile == PROF_NONE) ||
                 (i_state.last_speed != i_cfg.outbound_speed);

        mode0 = i_state.ramp_state;
        cnt0  = i_state.ramp_counter;
        if (reinit) begin
            case (profile)
                PROF_P1:  begin mode0 = MODE_P1;  cnt0 = i_cfg.point_low;  end
                PROF_P1N: begin mode0 = MODE_P1N; cnt0 = i_cfg.point_mid;  end
                default:  begin mode0 = MODE_P2;  cnt0 = i_cfg.point_high; end
            endcase
        end

        updated = !reinit && (profile != i_state.last_profile);
        blend   = manual ? manual_blend : cnt0;

        mode1 = updated ? fptr_next_mode(profile, i_state.last_profile) : mode0;
        if (manual) begin
            mode1 = MODE_MOVING;
        end

        speed  = i_state.toward_p2 ? i_cfg.outbound_speed : i_cfg.inbound_speed;
        period = PERIOD_W'(speed) * PERIOD_W'(TPU);
        fire   = (!manual && (i_state.tick_timer > TIMER_W'(period))) || updated;

        mode2       = mode1;
        cnt2        = cnt0;
        toward_next = i_state.toward_p2;
        tgt         = i_cfg.point_low;
        end_mode    = MODE_P1;
        do_ramp     = 1'b0;
        cnt_inc     = '0;
        cnt_dec     = '0;
        if (fire) begin
            case (mode1)
                MODE_P1:  cnt2 = i_cfg.point_low;
                MODE_P1N: cnt2 = i_cfg.point_mid;
                MODE_P2:  cnt2 = i_cfg.point_high;
                MODE_P1N_P1, MODE_P2_P1: begin
                    tgt = i_cfg.point_low;  end_mode = MODE_P1;
                    do_ramp = 1'b1; toward_next = 1'b0;
                end
                MODE_P1_P1N: begin
                    tgt = i_cfg.point_mid;  end_mode = MODE_P1N;
                    do_ramp = 1'b1; toward_next = 1'b1;
                end
                MODE_P2_P1N: begin
                    tgt = i_cfg.point_mid;  end_mode = MODE_P1N;
                    do_ramp = 1'b1; toward_next = 1'b0;
                end
                MODE_P1N_P2, MODE_P1_P2: begin
                    tgt = i_cfg.point_high; end_mode = MODE_P2;
                    do_ramp = 1'b1; toward_next = 1'b1;
                end
                default: cnt2 = cnt0;
            endcase
        end

        // One unit toward the target, snapping to it on arrival.
        if (do_ramp) begin
            if (cnt0 > tgt) begin
                cnt_dec = cnt0 - 7'd1;
                if (cnt_dec <= tgt) begin
                    cnt2 = tgt; mode2 = end_mode;
                end else begin
                    cnt2 = cnt_dec;
                end
            end else begin
                cnt_inc = {1'b0, cnt0} + 8'd1;
                if (cnt_inc >= {1'b0, tgt}) begin
                    cnt2 = tgt; mode2 = end_mode;
                end else begin
                    cnt2 = cnt_inc[POINT_W-1:0];
                end
            end
        end

        timer_next = (fire ? '0 : i_state.tick_timer) + 16'd1;

        o_state.last_profile = profile;
        o_state.last_speed   = i_cfg.outbound_speed;
        o_state.ramp_state   = mode2;
        o_state.ramp_counter = cnt2;
        o_state.toward_p2    = toward_next;
        o_state.tick_timer   = timer_next;
        o_state.prev_state   = mode2;
        o_state.prev_blend   = blend;
    end

    // Outputs: blend value, mode, integrator clears and the IMU reset request.
    always_comb begin
        clr2 = (mode2 == MODE_P1) || (blend == i_cfg.point_low);
        clr1 = !clr2 && ((mode2 == MODE_P2) || (blend == i_cfg.point_high));
        imu  = 1'b0;
        if (i_cfg.orient_reset_enable) begin
            if (!manual) begin
                imu = (mode2 != i_state.prev_state) &&
                      ((i_state.prev_state == MODE_P1) || (i_state.prev_state == MODE_P2));
            end else begin
                imu = ((i_state.prev_blend == i_cfg.point_low) && (blend > i_cfg.point_low)) ||
                      ((i_state.prev_blend == i_cfg.point_high) && (blend < i_cfg.point_high));
            end
        end

        o_result.blend_value       = blend;
        o_result.mode_state        = mode2;
        o_result.clear_p2_integral = clr2;
        o_result.clear_p1_integral = clr1;
        o_result.imu_reset         = imu;
    end

endmodule

// ===== rtl/flight_profile_transition_ramp_unit.sv =====
// Flight profile transition ramp, top level.
// An accepted item is held in the input register, then its result is stored in the result register.
// Throughput: one item per cycle unless the result register is full and not drained; the ramp
// state is updated by the step logic between the input register and the result register.
// Reset (synchronous, active low) empties both registers, loads the register
// reset values and puts the ramp back into its not-initialized state.
module flight_profile_transition_ramp_unit
    import fptr_pkg::*;
#(
    parameter int TICKS_PER_UNIT = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fptr_in_if.sink              i_in,
    fptr_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg                      cfg;
    t_state                    r_state;
    t_state                    n_state;
    t_result                   step_result;
    logic                      r_in_valid;
    logic signed [STICK_W-1:0] r_stick;
    logic                      r_out_valid;
    t_result                   r_result;
    logic                      advance;

    fptr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fptr_step #(
        .TICKS_PER_UNIT (TICKS_PER_UNIT)
    ) u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_stick  (r_stick),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // The registered item moves on whenever the result register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_stick <= i_in.profile_stick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_profile <= PROF_NONE;
            r_state.last_speed   <= '0;
            r_state.ramp_state   <= MODE_P1;
            r_state.ramp_counter <= '0;
            r_state.toward_p2    <= 1'b1;
            r_state.tick_timer   <= '0;
            r_state.prev_state   <= MODE_P1;
            r_state.prev_blend   <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.blend_value       = r_result.blend_value;
    assign o_out.mode_state        = r_result.mode_state;
    assign o_out.clear_p2_integral = r_result.clear_p2_integral;
    assign o_out.clear_p1_integral = r_result.clear_p1_integral;
    assign o_out.imu_reset         = r_result.imu_reset;

endmodule
